// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CWR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwr assertion failed");

// antecedent implies consequent in the next cycle
`define CWR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwr assertion failed");

`endif

// ===== hdl/cwr_pkg.sv =====
// types and constants of the cid width range encoder
package cwr_pkg;

    localparam int CODE_BITS    = 16;
    localparam int WIDTH_BITS   = 16;
    localparam int VALUE_BITS   = 16;
    localparam int COUNT_BITS   = CODE_BITS + 1;
    localparam int SUM_BITS     = CODE_BITS + 2;
    localparam int JOB_WORDS    = 3;
    localparam int JOB_IDX_BITS = $clog2(JOB_WORDS);
    localparam int JOB_CNT_BITS = $clog2(JOB_WORDS + 1);
    localparam int QDEPTH       = 4;
    localparam int QPTR_BITS    = $clog2(QDEPTH);
    localparam int QFILL_BITS   = QPTR_BITS + 1;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_ENTRY  = 2'd1,
        CMD_FINISH = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        KIND_RUN_FIRST  = 3'd0,
        KIND_RUN_LAST   = 3'd1,
        KIND_RUN_WIDTH  = 3'd2,
        KIND_LIST_FIRST = 3'd3,
        KIND_LIST_WIDTH = 3'd4,
        KIND_LIST_CLOSE = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [VALUE_BITS-1:0]  value;
    } word_t;

    typedef struct packed {
        logic [JOB_CNT_BITS-1:0]   count;
        word_t [JOB_WORDS-1:0]     words;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic word_t mk_word(kind_t kind, logic [VALUE_BITS-1:0] value);
        word_t w;
        w.kind  = kind;
        w.value = value;
        return w;
    endfunction

endpackage

// ===== hdl/cwr_ifs.sv =====
// handshake interfaces for input entries and output array words
interface cwr_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [cwr_pkg::CODE_BITS-1:0] code;
    logic [cwr_pkg::WIDTH_BITS-1:0] glyph_width;

    modport source (output valid, output command, output code, output glyph_width,
                    input ready);
    modport sink   (input valid, input command, input code, input glyph_width,
                    output ready);
endinterface

interface cwr_out_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     kind;
    logic [cwr_pkg::VALUE_BITS-1:0] value;
    logic                           last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== hdl/cwr_front.sv =====
// front end: accepts entries, tracks the open group, builds word jobs
module cwr_front (
    input  logic               clk,
    input  logic               rst_n,
    cwr_in_if.sink             item,
    input  cwr_pkg::q_status_t qstat,
    output logic               push,
    output cwr_pkg::job_t      push_job
);
    import cwr_pkg::*;

    logic [CODE_BITS-1:0]  start_reg, start_next;
    logic [WIDTH_BITS-1:0] pw_reg, pw_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  open_reg, open_next;

    logic [SUM_BITS-1:0]   sum;
    logic [CODE_BITS-1:0]  last_code;
    logic                  code_match;
    logic                  accept;
    job_t                  close_job;
    job_t                  job;

    assign sum        = SUM_BITS'(start_reg) + SUM_BITS'(count_reg);
    assign last_code  = CODE_BITS'(sum - 1'b1);
    assign code_match = (SUM_BITS'(item.code) == sum);
    assign accept     = item.valid && item.ready;
    assign item.ready = !qstat.full;

    // words that close the open group
    always_comb
    begin
        close_job = '0;
        if (open_reg)
        begin
            close_job.count    = JOB_CNT_BITS'(2);
            close_job.words[0] = mk_word(KIND_LIST_WIDTH, VALUE_BITS'(pw_reg));
            close_job.words[1] = mk_word(KIND_LIST_CLOSE, '0);
        end
        else if (count_reg == COUNT_BITS'(1))
        begin
            close_job.count    = JOB_CNT_BITS'(3);
            close_job.words[0] = mk_word(KIND_LIST_FIRST, VALUE_BITS'(start_reg));
            close_job.words[1] = mk_word(KIND_LIST_WIDTH, VALUE_BITS'(pw_reg));
            close_job.words[2] = mk_word(KIND_LIST_CLOSE, '0);
        end
        else
        begin
            close_job.count    = JOB_CNT_BITS'(3);
            close_job.words[0] = mk_word(KIND_RUN_FIRST, VALUE_BITS'(start_reg));
            close_job.words[1] = mk_word(KIND_RUN_LAST, VALUE_BITS'(last_code));
            close_job.words[2] = mk_word(KIND_RUN_WIDTH, VALUE_BITS'(pw_reg));
        end
    end

    always_comb
    begin
        start_next = start_reg;
        pw_next    = pw_reg;
        count_next = count_reg;
        open_next  = open_reg;
        job        = '0;
        case (item.command)
            CMD_START:
            begin
                start_next = '0;
                pw_next    = item.glyph_width;
                count_next = COUNT_BITS'(1);
                open_next  = 1'b0;
            end
            CMD_ENTRY:
            begin
                if (item.code != '0)
                begin
                    if (!code_match)
                    begin
                        job        = close_job;
                        start_next = item.code;
                        pw_next    = item.glyph_width;
                        count_next = COUNT_BITS'(1);
                        open_next  = 1'b0;
                    end
                    else if (item.glyph_width != pw_reg)
                    begin
                        if (count_reg != COUNT_BITS'(1) && !open_reg)
                        begin
                            // run ends, new group at this code
                            job        = close_job;
                            start_next = item.code;
                            pw_next    = item.glyph_width;
                            count_next = COUNT_BITS'(1);
                            open_next  = 1'b0;
                        end
                        else
                        begin
                            if (open_reg)
                            begin
                                job.count    = JOB_CNT_BITS'(1);
                                job.words[0] = mk_word(KIND_LIST_WIDTH, VALUE_BITS'(pw_reg));
                            end
                            else
                            begin
                                job.count    = JOB_CNT_BITS'(2);
                                job.words[0] = mk_word(KIND_LIST_FIRST,
                                                       VALUE_BITS'(start_reg));
                                job.words[1] = mk_word(KIND_LIST_WIDTH, VALUE_BITS'(pw_reg));
                            end
                            open_next  = 1'b1;
                            pw_next    = item.glyph_width;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (open_reg)
                    begin
                        // list ends, last two codes start a run
                        job.count    = JOB_CNT_BITS'(1);
                        job.words[0] = mk_word(KIND_LIST_CLOSE, '0);
                        open_next    = 1'b0;
                        start_next   = last_code;
                        count_next   = COUNT_BITS'(2);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            CMD_FINISH:
            begin
                job        = close_job;
                start_next = '0;
                pw_next    = '0;
                count_next = COUNT_BITS'(1);
                open_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign push     = accept && (job.count != '0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            pw_reg    <= '0;
            count_reg <= COUNT_BITS'(1);
            open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            start_reg <= start_next;
            pw_reg    <= pw_next;
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

endmodule

// ===== hdl/cwr_queue.sv =====
// job queue between front and back ends
module cwr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cwr_pkg::job_t      push_job,
    input  logic               pop,
    output cwr_pkg::job_t      head_job,
    output cwr_pkg::q_status_t qstat
);
    import cwr_pkg::*;

    job_t                  mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_reg, wr_next;
    logic [QPTR_BITS-1:0]  rd_reg, rd_next;
    logic [QFILL_BITS-1:0] fill_reg, fill_next;

    assign qstat.full  = (fill_reg == QFILL_BITS'(QDEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign head_job    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== hdl/cwr_back.sv =====
// back end: streams the words of the head job, one per cycle while result.ready is high
module cwr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cwr_pkg::job_t      head_job,
    input  cwr_pkg::q_status_t qstat,
    output logic               pop,
    cwr_out_if.source          result
);
    import cwr_pkg::*;

    logic [JOB_IDX_BITS-1:0] idx_reg, idx_next;
    word_t                   cur;
    logic                    is_last;
    logic                    fire;

    assign cur          = head_job.words[idx_reg];
    assign is_last      = (JOB_CNT_BITS'(idx_reg) == head_job.count - 1'b1);
    assign fire         = result.valid && result.ready;
    assign pop          = fire && is_last;
    assign result.valid = !qstat.empty;
    assign result.kind  = cur.kind;
    assign result.value = cur.value;
    assign result.last  = is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== hdl/cid_width_range_encoder.sv =====
// top level of the cid width range encoder
//
//  channel  dir  word                          handshake
//  item     in   command, code, glyph_width    valid/ready
//  result   out  kind, value, last             valid/ready
//
// an entry is taken every cycle while the four-job queue has room
// each entry yields zero to three result words, one word per cycle while result.ready is high
// sustained entry rate is set by the result port
// reset clears the group state and empties the queue
// a stalled result side fills the queue, then item.ready drops
`include "assert_macros.svh"

module cid_width_range_encoder (
    input  logic       clk,
    input  logic       rst_n,
    cwr_in_if.sink     item,
    cwr_out_if.source  result
);
    import cwr_pkg::*;

    q_status_t qstat;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;

    cwr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    cwr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    cwr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .qstat    (qstat),
        .pop      (pop),
        .result   (result)
    );

    `CWR_ASSERT_SAME(a_no_overflow, push, !qstat.full)
    `CWR_ASSERT_SAME(a_last_kind, result.valid && result.last,
        result.kind == KIND_RUN_WIDTH || result.kind == KIND_LIST_WIDTH ||
        result.kind == KIND_LIST_CLOSE)
    `CWR_ASSERT_NEXT(a_job_continues, result.valid && result.ready && !result.last,
        result.valid)
    `CWR_ASSERT_SAME(a_pushed_job_nonempty, push, push_job.count != '0)

endmodule
